FILE: rtl/mfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfd_pkg;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 136;
  localparam int ACC_W       = 48;
  localparam int SCALE_LAT   = 6;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [3:0] LEN_ENDSTOP = 4'd2;
  localparam logic [3:0] LEN_SHORT   = 4'd6;
  localparam logic [3:0] LEN_FULL    = 4'd8;

  localparam logic [3:0] TORQUE_HI_MASK = 4'h0F;

  typedef enum logic [1:0] {
    CLS_OTHER    = 2'd0,
    CLS_BAD_LEN  = 2'd1,
    CLS_ENDSTOP  = 2'd2,
    CLS_FEEDBACK = 2'd3
  } frame_class_t;

  typedef enum logic [2:0] {
    REG_NODE_ID     = 3'd0,
    REG_POS_MIN     = 3'd1,
    REG_POS_MAX     = 3'd2,
    REG_VEL_MIN     = 3'd3,
    REG_VEL_MAX     = 3'd4,
    REG_TORQUE_MIN  = 3'd5,
    REG_TORQUE_MAX  = 3'd6,
    REG_HOME_OFFSET = 3'd7
  } cfg_reg_t;

  // Linear scale settings handed to a scaler: magnitude and sign of the span, and its low end.
  typedef struct packed {
    logic               neg;
    logic        [31:0] mag;
    logic signed [31:0] lo;
  } scale_cfg_t;

  typedef struct packed {
    frame_class_t cls;
    logic         len8;
    logic         stop;
    logic [7:0]   temp;
    logic [7:0]   err;
  } side_t;

  function automatic scale_cfg_t make_scale(input logic signed [31:0] lo,
                                            input logic signed [31:0] hi);
    logic signed [32:0] span;
    logic        [32:0] negspan;
    scale_cfg_t         c;
    span    = {hi[31], hi} - {lo[31], lo};
    negspan = 33'd0 - span;
    c.lo    = lo;
    c.neg   = span[32];
    c.mag   = span[32] ? negspan[31:0] : span[31:0];
    return c;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat48(input logic [ACC_W:0] v);
    if (v[ACC_W] != v[ACC_W-1]) begin
      return v[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return v[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/motor_feedback_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes one motor feedback CAN frame per word on the slave stream and
// returns one result word per frame on the master stream, classed in tuser
// (other node, bad length, endstop, feedback). A new frame is taken every
// clock unless the master stream stalls; a result passes through the
// input register, the six-stage constant-divider pipeline of the position,
// velocity and torque scalers, the unwrap stage and the output register.
// The unwrap state loop closes in a single stage, so back-to-back frames
// carry no penalty. The result always shows the held motor state, also for
// frames that are ignored. Write the scale and offset registers only while
// no frame is in flight; config, held state and valid flags reset to zero.
module motor_feedback_frame_decoder #(
  parameter int POS_BITS = 16,
  parameter int VT_BITS  = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // frame_len[3:0], byte0..byte7 from bit 4 up, zero pad
  input  wire logic [mfd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // position[47:0], velocity, torque, temperature, error_code, endstop,
  // wrap_saturated, zero pad
  output logic [mfd_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // frame_class[1:0]
  output logic [1:0]                              m_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [2:0]                         cfg_index,
  input  wire logic [31:0]                        cfg_data
);

  localparam int LAT = mfd_pkg::SCALE_LAT;
  localparam int AW  = mfd_pkg::ACC_W;

  logic [7:0]         node_id;
  logic signed [31:0] pos_min;
  logic signed [31:0] pos_max;
  logic signed [31:0] vel_min;
  logic signed [31:0] vel_max;
  logic signed [31:0] torque_min;
  logic signed [31:0] torque_max;
  logic signed [31:0] home_offset;

  logic signed [31:0]  last_wrapped_pos;
  logic signed [AW-1:0] wrap_accum;
  logic signed [AW-1:0] wrap_accum_next;
  logic signed [31:0]  held_velocity;
  logic signed [31:0]  held_torque;
  logic [7:0]          held_temperature;
  logic [7:0]          held_error;
  logic                endstop_flag;

  logic                              en;
  logic [mfd_pkg::IN_TDATA_W-1:0]    in_q;
  logic                              in_v;
  mfd_pkg::side_t                    side_q [0:LAT-1];
  logic [LAT-1:0]                    side_v;
  mfd_pkg::frame_class_t             g_cls;
  logic                              g_v;

  logic [3:0]            len;
  logic [7:0]            b [0:7];
  mfd_pkg::side_t        dec;
  logic [15:0]           pfield;
  logic [11:0]           vfield;
  logic [11:0]           tfield;
  logic [POS_BITS-1:0]   praw;
  logic [VT_BITS-1:0]    vraw;
  logic [VT_BITS-1:0]    traw;

  mfd_pkg::scale_cfg_t pos_cfg;
  mfd_pkg::scale_cfg_t vel_cfg;
  mfd_pkg::scale_cfg_t tq_cfg;
  logic signed [31:0]  pos_val;
  logic signed [31:0]  vel_val;
  logic signed [31:0]  tq_val;

  logic signed [32:0]  range;
  logic signed [32:0]  delta;
  logic        [32:0]  adelta;
  logic                wrap;
  logic [AW:0]         acc_sum;
  logic [AW:0]         pos_sum;
  logic signed [AW-1:0] position;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_id     <= '0;
      pos_min     <= '0;
      pos_max     <= '0;
      vel_min     <= '0;
      vel_max     <= '0;
      torque_min  <= '0;
      torque_max  <= '0;
      home_offset <= '0;
    end else if (cfg_valid) begin
      case (mfd_pkg::cfg_reg_t'(cfg_index))
        mfd_pkg::REG_NODE_ID:     node_id     <= cfg_data[7:0];
        mfd_pkg::REG_POS_MIN:     pos_min     <= cfg_data;
        mfd_pkg::REG_POS_MAX:     pos_max     <= cfg_data;
        mfd_pkg::REG_VEL_MIN:     vel_min     <= cfg_data;
        mfd_pkg::REG_VEL_MAX:     vel_max     <= cfg_data;
        mfd_pkg::REG_TORQUE_MIN:  torque_min  <= cfg_data;
        mfd_pkg::REG_TORQUE_MAX:  torque_max  <= cfg_data;
        mfd_pkg::REG_HOME_OFFSET: home_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pos_cfg = mfd_pkg::make_scale(pos_min, pos_max);
  assign vel_cfg = mfd_pkg::make_scale(vel_min, vel_max);
  assign tq_cfg  = mfd_pkg::make_scale(torque_min, torque_max);

  // Input register
  always_ff @(posedge clk) begin
    if (en) begin
      in_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v   <= 1'b0;
      side_v <= '0;
      g_v    <= 1'b0;
    end else if (en) begin
      in_v   <= s_axis_tvalid;
      side_v <= {side_v[LAT-2:0], in_v};
      g_v    <= side_v[LAT-1];
    end
  end

  // Frame decode
  always_comb begin
    len = in_q[3:0];
    for (int i = 0; i < 8; i++) begin
      b[i] = in_q[4 + 8 * i +: 8];
    end
    pfield = {b[1], b[2]};
    vfield = {b[3], b[4][7:4]};
    tfield = {b[4][3:0] & mfd_pkg::TORQUE_HI_MASK, b[5]};
    praw   = POS_BITS'(pfield);
    vraw   = VT_BITS'(vfield);
    traw   = VT_BITS'(tfield);

    dec.len8 = (len == mfd_pkg::LEN_FULL);
    dec.stop = (b[1] != 8'd0);
    dec.temp = b[6];
    dec.err  = b[7];
    if (b[0] != node_id) begin
      dec.cls = mfd_pkg::CLS_OTHER;
    end else begin
      case (len)
        mfd_pkg::LEN_ENDSTOP:                    dec.cls = mfd_pkg::CLS_ENDSTOP;
        mfd_pkg::LEN_SHORT, mfd_pkg::LEN_FULL:   dec.cls = mfd_pkg::CLS_FEEDBACK;
        default:                                 dec.cls = mfd_pkg::CLS_BAD_LEN;
      endcase
    end
  end

  // Side information follows the scalers word for word
  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= dec;
      for (int k = 1; k < LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  mfd_scale #(.BITS(POS_BITS)) u_pos_scale (
    .clk   (clk),
    .en    (en),
    .cfg   (pos_cfg),
    .raw   (praw),
    .value (pos_val)
  );

  mfd_scale #(.BITS(VT_BITS)) u_vel_scale (
    .clk   (clk),
    .en    (en),
    .cfg   (vel_cfg),
    .raw   (vraw),
    .value (vel_val)
  );

  mfd_scale #(.BITS(VT_BITS)) u_tq_scale (
    .clk   (clk),
    .en    (en),
    .cfg   (tq_cfg),
    .raw   (traw),
    .value (tq_val)
  );

  // Multi-turn unwrap: a jump beyond half the range, or any feedback when the range is negative, moves the turn offset
  always_comb begin
    range  = {pos_max[31], pos_max} - {pos_min[31], pos_min};
    delta  = {pos_val[31], pos_val} - {last_wrapped_pos[31], last_wrapped_pos};
    adelta = delta[32] ? (33'd0 - delta) : delta;
    wrap   = range[32] || ({adelta, 1'b0} > {2'b00, range[31:0]});
    if (!delta[32] && (delta != '0)) begin
      acc_sum = {wrap_accum[AW-1], wrap_accum} - (AW + 1)'(range);
    end else begin
      acc_sum = {wrap_accum[AW-1], wrap_accum} + (AW + 1)'(range);
    end
    wrap_accum_next = wrap ? mfd_pkg::sat48(acc_sum) : wrap_accum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_wrapped_pos <= '0;
      wrap_accum       <= '0;
      held_velocity    <= '0;
      held_torque      <= '0;
      held_temperature <= '0;
      held_error       <= '0;
      endstop_flag     <= 1'b0;
    end else if (en && side_v[LAT-1]) begin
      case (side_q[LAT-1].cls)
        mfd_pkg::CLS_ENDSTOP: begin
          endstop_flag <= side_q[LAT-1].stop;
        end
        mfd_pkg::CLS_FEEDBACK: begin
          held_velocity    <= vel_val;
          held_torque      <= tq_val;
          last_wrapped_pos <= pos_val;
          wrap_accum       <= wrap_accum_next;
          if (side_q[LAT-1].len8) begin
            held_temperature <= side_q[LAT-1].temp;
            held_error       <= side_q[LAT-1].err;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_cls <= side_q[LAT-1].cls;
    end
  end

  // Output register reads the state left by this word
  always_comb begin
    pos_sum  = {wrap_accum[AW-1], wrap_accum}
             + (AW + 1)'(last_wrapped_pos)
             - (AW + 1)'(home_offset);
    position = mfd_pkg::sat48(pos_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tuser <= g_cls;
      m_axis_tdata <= {6'd0,
                       (wrap_accum == mfd_pkg::ACC_MAX) || (wrap_accum == mfd_pkg::ACC_MIN),
                       endstop_flag,
                       held_error,
                       held_temperature,
                       held_torque,
                       held_velocity,
                       position};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mfd_scale.sv
`timescale 1ns / 1ps
`default_nettype none

// value = lo + floor(raw * span / (2^BITS - 1)), pipelined over six stages.
// The divide by 2^BITS - 1 multiplies by (1 + 2^B)(1 + 2^2B)(1 + 2^4B)...
// with shift-adds, takes the top bits, then fixes the one-low case.
module mfd_scale #(
  parameter int BITS = 12
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire mfd_pkg::scale_cfg_t cfg,
  input  wire logic [BITS-1:0]     raw,
  output logic signed [31:0]       value
);

  localparam int XW   = BITS + 32;
  localparam int NDBL = (2 * BITS >= XW) ? 1 : ((4 * BITS >= XW) ? 2 : 3);
  localparam int NB   = BITS << NDBL;
  localparam int ZW   = XW + NB;
  localparam int QW   = XW - BITS + 1;
  localparam logic [BITS:0] DIV = {1'b0, {BITS{1'b1}}};

  logic [XW-1:0] x_q [0:3];
  logic [ZW-1:0] z_q [1:3];
  logic [QW-1:0] q_q;
  logic          rnz_q;

  logic [QW-1:0] qe;
  logic [BITS:0] rem;
  logic [BITS:0] rem_adj;
  logic [QW-1:0] q_fix;
  logic          rnz;
  logic [QW:0]   mag;
  logic [QW:0]   sval;
  logic [QW:0]   sum;

  function automatic logic [ZW-1:0] dbl(input logic [ZW-1:0] v, input int k);
    if (k < NDBL) begin
      return v + (v << (BITS << k));
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0] <= XW'(raw) * XW'(cfg.mag);
      x_q[1] <= x_q[0];
      x_q[2] <= x_q[1];
      x_q[3] <= x_q[2];
      z_q[1] <= dbl(ZW'(x_q[0]), 0);
      z_q[2] <= dbl(z_q[1], 1);
      z_q[3] <= dbl(z_q[2], 2);
      q_q    <= q_fix;
      rnz_q  <= rnz;
      value  <= sum[31:0];
    end
  end

  // Estimate is exact or one low; the low bits of the remainder decide.
  always_comb begin
    qe      = z_q[3][NB +: QW];
    rem     = x_q[3][BITS:0] - {qe[0], {BITS{1'b0}}} + qe[BITS:0];
    rem_adj = rem - DIV;
    if (rem >= DIV) begin
      q_fix = qe + QW'(1);
      rnz   = (rem_adj != '0);
    end else begin
      q_fix = qe;
      rnz   = (rem != '0);
    end
  end

  // Floor towards minus infinity when the span is negative.
  always_comb begin
    mag  = {1'b0, q_q} + (QW + 1)'(cfg.neg & rnz_q);
    sval = cfg.neg ? ((QW + 1)'(0) - mag) : mag;
    sum  = (QW + 1)'(cfg.lo) + sval;
  end

endmodule

`default_nettype wire

FILE: rtl/mfd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mfd_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_axis_tready,
  input wire logic [mfd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input wire logic [1:0]                         m_axis_tuser,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready
);

  logic                              have_prev;
  logic [mfd_pkg::OUT_TDATA_W-1:0]   prev_data;
  logic                              out_acc;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Remember the last delivered word
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (out_acc) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_data <= m_axis_tdata;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid straight after reset");

  a_take_when_free: assert property (@(posedge clk)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with an empty output register");

  a_ignored_holds: assert property (@(posedge clk) disable iff (rst)
    out_acc && have_prev &&
      (m_axis_tuser == mfd_pkg::CLS_OTHER || m_axis_tuser == mfd_pkg::CLS_BAD_LEN) |->
      m_axis_tdata[129:48] == prev_data[129:48])
    else $error("ignored frame changed held state");

  a_endstop_holds: assert property (@(posedge clk) disable iff (rst)
    out_acc && have_prev && (m_axis_tuser == mfd_pkg::CLS_ENDSTOP) |->
      m_axis_tdata[127:48] == prev_data[127:48] && m_axis_tdata[129] == prev_data[129])
    else $error("endstop frame changed feedback state");

endmodule

bind motor_feedback_frame_decoder mfd_checker u_mfd_checker (.*);

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import mfd_pkg::*;

  localparam int POS_BITS = 16;
  localparam int VT_BITS = 12;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_FRAMES = 200;
  localparam int SINK_CHUNK = 1024;

  typedef struct packed {
    logic [3:0]  pad;
    logic [63:0] pay;   // byte i at pay[8*i +: 8]
    logic [3:0]  len;
  } can_frame_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic        sat;
    logic        stop;
    logic [7:0]  err;
    logic [7:0]  temp;
    logic [31:0] trq;
    logic [31:0] vel;
    logic [47:0] pos;
  } feedback_word_t;

  typedef struct packed {
    frame_class_t   cls;
    feedback_word_t fb;
  } joint_result_t;

  typedef enum {
    SET_TYPICAL,
    SET_FULL_SPAN,
    SET_INVERTED,
    SET_ZERO_SPAN,
    SET_RANDOM,
    SET_UNWRAP_SINK
  } setting_kind_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [2:0]             cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  // joint settings as last written
  logic [7:0]         node_sel = '0;
  logic signed [31:0] pos_lo = '0;
  logic signed [31:0] pos_hi = '0;
  logic signed [31:0] vel_lo = '0;
  logic signed [31:0] vel_hi = '0;
  logic signed [31:0] trq_lo = '0;
  logic signed [31:0] trq_hi = '0;
  logic signed [31:0] home_shift = '0;

  // joint state
  longint     last_pos = 0;
  longint     turn_acc = 0;
  longint     vel_hold = 0;
  longint     trq_hold = 0;
  logic [7:0] temp_hold = '0;
  logic [7:0] err_hold = '0;
  logic       stop_hold = 1'b0;

  can_frame_t    frames_waiting [$];
  joint_result_t feedback_owed [$];
  int            mismatches = 0;
  int            feed_gap = 0;
  bit            feed_lazy = 1'b1;
  int            sink_hold = 0;
  int            sink_stall = 0;
  bit            sink_lazy = 1'b1;

  always #4 clk = ~clk;

  motor_feedback_frame_decoder #(
    .POS_BITS(POS_BITS),
    .VT_BITS (VT_BITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  function automatic longint clamp_acc(longint v);
    if (v > longint'(ACC_MAX)) return longint'(ACC_MAX);
    if (v < longint'(ACC_MIN)) return longint'(ACC_MIN);
    return v;
  endfunction

  // lo + floor(raw * (hi - lo) / (2^bits - 1))
  function automatic longint scaled(longint raw, longint lo, longint hi, int bits);
    longint den;
    longint prod;
    longint quo;
    den = (64'sd1 <<< bits) - 1;
    prod = raw * (hi - lo);
    quo = prod / den;
    if (prod % den != 0 && prod < 0) quo -= 1;
    return lo + quo;
  endfunction

  task automatic decode_frame(can_frame_t f);
    joint_result_t want;
    longint        praw;
    longint        vraw;
    longint        traw;
    longint        span;
    longint        cur;
    longint        step;
    want = '0;
    if (f.pay[7:0] != node_sel) begin
      want.cls = CLS_OTHER;
    end else if (f.len != LEN_ENDSTOP && f.len != LEN_SHORT && f.len != LEN_FULL) begin
      want.cls = CLS_BAD_LEN;
    end else if (f.len == LEN_ENDSTOP) begin
      want.cls = CLS_ENDSTOP;
      stop_hold = (f.pay[15:8] != 8'h00);
    end else begin
      want.cls = CLS_FEEDBACK;
      praw = {f.pay[15:8], f.pay[23:16]} & ((64'd1 << POS_BITS) - 1);
      vraw = {f.pay[31:24], f.pay[39:36]} & ((64'd1 << VT_BITS) - 1);
      traw = {f.pay[35:32], f.pay[47:40]} & ((64'd1 << VT_BITS) - 1);
      if (f.len == LEN_FULL) begin
        temp_hold = f.pay[55:48];
        err_hold = f.pay[63:56];
      end
      vel_hold = scaled(vraw, longint'(vel_lo), longint'(vel_hi), VT_BITS);
      trq_hold = scaled(traw, longint'(trq_lo), longint'(trq_hi), VT_BITS);
      span = longint'(pos_hi) - longint'(pos_lo);
      cur = scaled(praw, longint'(pos_lo), longint'(pos_hi), POS_BITS);
      step = cur - last_pos;
      // a jump past half the span counts as a turn over the end stop
      if (2 * (step < 0 ? -step : step) > span) begin
        turn_acc = clamp_acc(step > 0 ? turn_acc - span : turn_acc + span);
      end
      last_pos = cur;
    end
    want.fb.pos = clamp_acc(turn_acc + last_pos - longint'(home_shift));
    want.fb.vel = vel_hold[31:0];
    want.fb.trq = trq_hold[31:0];
    want.fb.temp = temp_hold;
    want.fb.err = err_hold;
    want.fb.stop = stop_hold;
    want.fb.sat = (turn_acc == longint'(ACC_MAX)) || (turn_acc == longint'(ACC_MIN));
    feedback_owed.push_back(want);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    end
  endtask

  task automatic check_result(frame_class_t cls, feedback_word_t got);
    joint_result_t want;
    if (feedback_owed.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: result word with none expected", $time);
    end else begin
      want = feedback_owed.pop_front();
      check_field("frame_class", want.cls, cls);
      check_field("position", want.fb.pos, got.pos);
      check_field("velocity", want.fb.vel, got.vel);
      check_field("torque", want.fb.trq, got.trq);
      check_field("temperature", want.fb.temp, got.temp);
      check_field("error_code", want.fb.err, got.err);
      check_field("endstop", want.fb.stop, got.stop);
      check_field("wrap_saturated", want.fb.sat, got.sat);
    end
  endtask

  // sender: one word in flight, a random gap drawn per word in lazy phases
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      feed_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_frame(can_frame_t'(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (feed_gap != 0) begin
          feed_gap <= feed_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (frames_waiting.size() != 0) begin
          s_axis_tdata <= frames_waiting.pop_front();
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 63) == 0) feed_lazy = !feed_lazy;
          feed_gap <= feed_lazy ? $urandom_range(0, 3) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: in lazy phases, hold tready low for a randomly drawn stall after each word
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_hold <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      check_result(frame_class_t'(m_axis_tuser), feedback_word_t'(m_axis_tdata));
      if ($urandom_range(0, 63) == 0) sink_lazy = !sink_lazy;
      sink_stall = sink_lazy ? $urandom_range(0, 3) : 0;
      m_axis_tready <= (sink_stall == 0);
      sink_hold <= (sink_stall == 0) ? 0 : sink_stall - 1;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NODE_ID:     node_sel = value[7:0];
      REG_POS_MIN:     pos_lo = value;
      REG_POS_MAX:     pos_hi = value;
      REG_VEL_MIN:     vel_lo = value;
      REG_VEL_MAX:     vel_hi = value;
      REG_TORQUE_MIN:  trq_lo = value;
      REG_TORQUE_MAX:  trq_hi = value;
      REG_HOME_OFFSET: home_shift = value;
      default: ;
    endcase
  endtask

  task automatic load_setting(setting_kind_t kind);
    logic [7:0]  node;
    logic [31:0] plo, phi, vlo, vhi, tlo, thi, home, p, v, t;
    node = $urandom;
    p = $urandom_range(1 << 16, 40 << 16);
    v = $urandom_range(1 << 16, 80 << 16);
    t = $urandom_range(1 << 14, 30 << 16);
    plo = 32'd0 - p;
    phi = p;
    vlo = 32'd0 - v;
    vhi = v;
    tlo = 32'd0 - t;
    thi = t;
    home = $urandom_range(0, 2 * p) - p;
    case (kind)
      SET_FULL_SPAN: begin
        node = 8'hFF;
        plo = 32'h8000_0000;
        phi = 32'h7FFF_FFFF;
        vlo = plo;
        vhi = phi;
        tlo = plo;
        thi = phi;
        home = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      SET_INVERTED: begin
        node = 8'h00;
        {plo, phi} = {phi, plo};
        {vlo, vhi} = {vhi, vlo};
        {tlo, thi} = {thi, tlo};
      end
      SET_ZERO_SPAN: begin
        plo = $urandom;
        phi = plo;
        vlo = $urandom;
        vhi = vlo;
        tlo = $urandom;
        thi = tlo;
        home = $urandom;
      end
      SET_RANDOM: begin
        {plo, phi, vlo, vhi, tlo, thi, home} = {$urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom};
      end
      SET_UNWRAP_SINK: begin
        // widest negative span: every frame that does not raise the position turns the accumulator down
        plo = 32'h7FFF_FFFF;
        phi = 32'h8000_0000;
        home = $urandom;
      end
      default: ;
    endcase
    // stray bits above the id must be dropped
    write_reg(REG_NODE_ID, ($urandom_range(0, 1) ? ($urandom & 32'hFFFF_FF00) : 0) | node);
    write_reg(REG_POS_MIN, plo);
    write_reg(REG_POS_MAX, phi);
    write_reg(REG_VEL_MIN, vlo);
    write_reg(REG_VEL_MAX, vhi);
    write_reg(REG_TORQUE_MIN, tlo);
    write_reg(REG_TORQUE_MAX, thi);
    write_reg(REG_HOME_OFFSET, home);
  endtask

  function automatic can_frame_t fb_frame(logic [3:0] len, logic [15:0] praw,
                                          logic [11:0] vraw, logic [11:0] traw,
                                          logic [7:0] temp, logic [7:0] err);
    can_frame_t f;
    f = '0;
    f.len = len;
    f.pay = {err, temp, traw[7:0], vraw[3:0], traw[11:8], vraw[11:4],
             praw[7:0], praw[15:8], node_sel};
    return f;
  endfunction

  function automatic can_frame_t raw_frame(logic [3:0] len, logic [7:0] b0, logic [7:0] b1);
    can_frame_t f;
    f = '0;
    f.len = len;
    f.pay = {$urandom, $urandom};
    f.pay[7:0] = b0;
    f.pay[15:8] = b1;
    return f;
  endfunction

  function automatic can_frame_t random_frame();
    can_frame_t f;
    int         pick;
    f = raw_frame(LEN_FULL, node_sel, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      f.len = $urandom;
      f.pay[7:0] = node_sel ^ $urandom_range(1, 255);
    end else if (pick < 16) begin
      do f.len = $urandom;
      while (f.len == LEN_ENDSTOP || f.len == LEN_SHORT || f.len == LEN_FULL);
    end else if (pick < 30) begin
      f.len = LEN_ENDSTOP;
      if ($urandom_range(0, 1)) f.pay[15:8] = 8'h00;
    end else begin
      f.len = $urandom_range(0, 1) ? LEN_FULL : LEN_SHORT;
      case ($urandom_range(0, 9))
        0: f.pay[47:8] = '0;
        1: f.pay[47:8] = '1;
        default: ;
      endcase
    end
    return f;
  endfunction

  task automatic drain();
    while (frames_waiting.size() != 0 || s_axis_tvalid || feedback_owed.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    #16_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    setting_kind_t plan [7];
    logic [15:0]   hold_raw;
    int            chunk;
    plan = '{SET_TYPICAL, SET_FULL_SPAN, SET_INVERTED, SET_ZERO_SPAN,
             SET_RANDOM, SET_TYPICAL, SET_RANDOM};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    load_setting(SET_TYPICAL);
    // first feedback after reset unwraps against zero
    frames_waiting.push_back(fb_frame(LEN_FULL, 16'h0000, 12'h000, 12'h000, 8'h00, 8'h00));
    frames_waiting.push_back(fb_frame(LEN_FULL, 16'hFFFF, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF));
    frames_waiting.push_back(fb_frame(LEN_SHORT, 16'h0000, 12'h800, 12'h7FF, 8'h00, 8'h00));
    frames_waiting.push_back(fb_frame(LEN_SHORT, 16'h8000, 12'h7FF, 12'h800, 8'h12, 8'h34));
    frames_waiting.push_back(fb_frame(LEN_SHORT, 16'h0000, 12'h001, 12'hFFE, 8'h00, 8'h00));
    frames_waiting.push_back(fb_frame(LEN_FULL, 16'h7FFF, 12'hABC, 12'h543, 8'h5A, 8'hA5));
    frames_waiting.push_back(raw_frame(LEN_ENDSTOP, node_sel, 8'h01));
    frames_waiting.push_back(raw_frame(LEN_ENDSTOP, node_sel, 8'h00));
    frames_waiting.push_back(raw_frame(LEN_ENDSTOP, node_sel, 8'h80));
    // other node: no update even for a well-formed frame
    frames_waiting.push_back(raw_frame(LEN_FULL, node_sel ^ 8'h01, 8'h00));
    frames_waiting.push_back(raw_frame(LEN_ENDSTOP, ~node_sel, 8'h00));
    frames_waiting.push_back(raw_frame(4'd0, node_sel, 8'h00));
    frames_waiting.push_back(raw_frame(4'd1, node_sel, 8'h00));
    frames_waiting.push_back(raw_frame(4'd3, node_sel, 8'h00));
    frames_waiting.push_back(raw_frame(4'd4, node_sel, 8'h00));
    frames_waiting.push_back(raw_frame(4'd5, node_sel, 8'h00));
    frames_waiting.push_back(raw_frame(4'd7, node_sel, 8'h00));
    frames_waiting.push_back(raw_frame(4'd9, node_sel, 8'h00));
    frames_waiting.push_back(raw_frame(4'd15, node_sel, 8'h00));
    frames_waiting.push_back(fb_frame(LEN_FULL, 16'h4000, 12'h000, 12'hFFF, 8'h00, 8'hFF));
    settle();

    foreach (plan[i]) begin
      load_setting(plan[i]);
      repeat (PHASE_FRAMES) frames_waiting.push_back(random_frame());
      settle();
    end

    // drive the turn accumulator onto its lower limit, then rock it off and back
    load_setting(SET_UNWRAP_SINK);
    hold_raw = $urandom;
    chunk = 0;
    while (turn_acc != longint'(ACC_MIN) && chunk < 64) begin
      repeat (SINK_CHUNK) begin
        frames_waiting.push_back(fb_frame($urandom_range(0, 1) ? LEN_FULL : LEN_SHORT,
          hold_raw, $urandom, $urandom, $urandom, $urandom));
      end
      drain();
      chunk++;
    end
    repeat (40) frames_waiting.push_back(random_frame());
    settle();

    if (mismatches == 0 && feedback_owed.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
